/* rtl/npd_pkg.sv */
package npd_pkg;

    // Defaults for the top-level parameters
    localparam int N_COEFFS_DEF = 256;
    localparam int Q_BITS_DEF   = 13;

    // Fixed beat field widths
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 8;
    localparam int COEFF_W  = 13;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD = 2'd0,
        OP_MAC  = 2'd1,
        OP_READ = 2'd2
    } t_opcode;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic load_we;    // write coefficient pair
        logic mac_start;  // MAC accepted (clear on clear_first)
        logic rd_en;      // s memory read at counter
        logic mac_step;   // one product row into the accumulator, shift a
        logic flip;       // a row has gone round once: toggle polarity
        logic rot_step;   // rotate accumulator row by one
        logic out_load;   // move read value into output register
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic in_range;   // incoming index below N_COEFFS
        logic out_busy;   // output register full and not being taken
    } t_sts;

endpackage

/* rtl/npd_ifs.sv */
interface npd_in_if;
    logic                          valid;
    logic                          ready;
    logic [npd_pkg::OPCODE_W-1:0]  opcode;
    logic [npd_pkg::INDEX_W-1:0]   coeff_index;
    logic [npd_pkg::COEFF_W-1:0]   s_coeff;
    logic [npd_pkg::COEFF_W-1:0]   a_coeff;
    logic                          clear_first;

    modport source (
        output valid, opcode, coeff_index, s_coeff, a_coeff, clear_first,
        input  ready
    );
    modport sink (
        input  valid, opcode, coeff_index, s_coeff, a_coeff, clear_first,
        output ready
    );
endinterface

interface npd_out_if;
    logic                         valid;
    logic                         ready;
    logic [npd_pkg::COEFF_W-1:0]  result_coeff;
    logic [npd_pkg::INDEX_W-1:0]  result_index;

    modport source (
        output valid, result_coeff, result_index,
        input  ready
    );
    modport sink (
        input  valid, result_coeff, result_index,
        output ready
    );
endinterface

/* rtl/npd_mac_cell.sv */
// One coefficient slot: a-row register and accumulator register.
module npd_mac_cell #(
    parameter int Q_BITS = npd_pkg::Q_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [Q_BITS-1:0] i_a_load,
    input  logic [Q_BITS-1:0] i_a_shift,
    input  logic [Q_BITS-1:0] i_s,
    input  logic              i_step,
    input  logic              i_clear,
    input  logic              i_rot,
    input  logic [Q_BITS-1:0] i_acc_rot,
    output logic [Q_BITS-1:0] o_a,
    output logic [Q_BITS-1:0] o_acc
);

    logic [Q_BITS-1:0] r_a;
    logic [Q_BITS-1:0] r_acc;
    logic [Q_BITS-1:0] w_prod;   // product mod 2^Q_BITS

    assign w_prod = i_s * r_a;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_a_load;
        end else if (i_step) begin
            r_a <= i_a_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            priority if (i_clear) begin
                r_acc <= '0;
            end else if (i_step) begin
                r_acc <= r_acc + w_prod;
            end else if (i_rot) begin
                r_acc <= i_acc_rot;
            end
        end
    end

    assign o_a   = r_a;
    assign o_acc = r_acc;

endmodule

/* rtl/npd_datapath.sv */
module npd_datapath #(
    parameter int N_COEFFS = npd_pkg::N_COEFFS_DEF,
    parameter int Q_BITS   = npd_pkg::Q_BITS_DEF,
    parameter int CNT_W    = $clog2(npd_pkg::N_COEFFS_DEF + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  npd_pkg::t_cmd                i_cmd,
    input  logic [CNT_W-1:0]             i_cnt,
    input  logic [npd_pkg::INDEX_W-1:0]  i_coeff_index,
    input  logic [npd_pkg::COEFF_W-1:0]  i_s_coeff,
    input  logic [npd_pkg::COEFF_W-1:0]  i_a_coeff,
    input  logic                         i_clear_first,
    input  logic                         i_out_ready,
    output npd_pkg::t_sts                o_sts,
    output logic                         o_out_valid,
    output logic [npd_pkg::COEFF_W-1:0]  o_result_coeff,
    output logic [npd_pkg::INDEX_W-1:0]  o_result_index
);

    localparam int IDX_W = $clog2(N_COEFFS);
    localparam int EXT_W = (IDX_W > npd_pkg::INDEX_W) ? IDX_W : npd_pkg::INDEX_W;

    logic [Q_BITS-1:0] r_s_mem [N_COEFFS];
    logic [Q_BITS-1:0] r_s_rd;
    logic              r_neg;   // a row currently holds -a (x^N = -1)

    logic [EXT_W-1:0]  w_in_idx_ext;
    logic [IDX_W-1:0]  w_in_idx;
    logic [Q_BITS-1:0] w_s_val;
    logic [Q_BITS-1:0] w_a_val;
    logic [Q_BITS-1:0] w_a_load;
    logic [Q_BITS-1:0] w_s_eff;
    logic [Q_BITS-1:0] w_a   [N_COEFFS];
    logic [Q_BITS-1:0] w_acc [N_COEFFS];

    logic [npd_pkg::INDEX_W-1:0] r_rd_index;
    logic [EXT_W-1:0]            w_rd_idx_ext;
    logic [Q_BITS-1:0]           r_rd_val;

    logic                         r_out_valid;
    logic [npd_pkg::COEFF_W-1:0]  r_out_coeff;
    logic [npd_pkg::INDEX_W-1:0]  r_out_index;

    assign w_in_idx_ext = EXT_W'(i_coeff_index);
    assign w_in_idx     = w_in_idx_ext[IDX_W-1:0];
    assign w_s_val      = Q_BITS'(i_s_coeff);
    assign w_a_val      = Q_BITS'(i_a_coeff);
    assign w_a_load     = r_neg ? (Q_BITS'(0) - w_a_val) : w_a_val;
    assign w_s_eff      = r_neg ? (Q_BITS'(0) - r_s_rd) : r_s_rd;
    assign w_rd_idx_ext = EXT_W'(r_rd_index);

    // s store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_s_mem[w_in_idx] <= w_s_val;
        end
        if (i_cmd.rd_en) begin
            r_s_rd <= r_s_mem[i_cnt[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg <= 1'b0;
        end else if (i_cmd.flip) begin
            r_neg <= ~r_neg;
        end
    end

    // Row of cells; a shifts negacyclically, accumulator rotates for reads
    for (genvar k = 0; k < N_COEFFS; k++) begin : g_cell
        logic [Q_BITS-1:0] w_a_shift;
        if (k == 0) begin : g_wrap
            assign w_a_shift = Q_BITS'(0) - w_a[N_COEFFS-1];
        end else begin : g_mid
            assign w_a_shift = w_a[k-1];
        end

        npd_mac_cell #(
            .Q_BITS (Q_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (i_cmd.load_we && (w_in_idx == IDX_W'(k))),
            .i_a_load  (w_a_load),
            .i_a_shift (w_a_shift),
            .i_s       (w_s_eff),
            .i_step    (i_cmd.mac_step),
            .i_clear   (i_cmd.mac_start && i_clear_first),
            .i_rot     (i_cmd.rot_step),
            .i_acc_rot (w_acc[(k + 1) % N_COEFFS]),
            .o_a       (w_a[k]),
            .o_acc     (w_acc[k])
        );
    end

    // Read capture: slot 0 holds coefficient cnt after cnt rotations
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_index <= i_coeff_index;
            r_rd_val   <= '0;
        end else if (i_cmd.rot_step &&
                     (i_cnt[IDX_W-1:0] == w_rd_idx_ext[IDX_W-1:0])) begin
            r_rd_val <= w_acc[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_coeff <= npd_pkg::COEFF_W'(r_rd_val);
            r_out_index <= r_rd_index;
        end
    end

    assign o_sts.in_range  = 32'(i_coeff_index) < 32'(N_COEFFS);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_result_coeff  = r_out_coeff;
    assign o_result_index  = r_out_index;

endmodule

/* rtl/npd_ctrl.sv */
module npd_ctrl #(
    parameter int N_COEFFS = npd_pkg::N_COEFFS_DEF,
    parameter int CNT_W    = $clog2(npd_pkg::N_COEFFS_DEF + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [npd_pkg::OPCODE_W-1:0]  i_opcode,
    input  npd_pkg::t_sts                 i_sts,
    output logic                          o_in_ready,
    output npd_pkg::t_cmd                 o_cmd,
    output logic [CNT_W-1:0]              o_cnt
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_COEFFS);
    localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(N_COEFFS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             w_fire;

    // no beat is taken while reset is held
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign w_fire     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = w_fire;
                n_cnt        = '0;
                if (w_fire) begin
                    unique case (npd_pkg::t_opcode'(i_opcode))
                        npd_pkg::OP_LOAD: begin
                            o_cmd.load_we = i_sts.in_range;
                        end
                        npd_pkg::OP_MAC: begin
                            o_cmd.mac_start = 1'b1;
                            n_state         = S_MAC;
                        end
                        npd_pkg::OP_READ: begin
                            n_state = i_sts.in_range ? S_READ : S_OUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MAC: begin
                // read s[cnt] while the product of s[cnt-1] goes in
                o_cmd.rd_en    = (r_cnt != CNT_LAST);
                o_cmd.mac_step = (r_cnt != '0);
                if (r_cnt == CNT_LAST) begin
                    o_cmd.flip = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_READ: begin
                o_cmd.rot_step = 1'b1;
                if (r_cnt == ROT_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

    a_mac_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_opcode == npd_pkg::OP_MAC)) |=> (r_state == S_MAC && r_cnt == '0))
        else $error("MAC did not start from count zero");

    a_mac_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_cnt <= CNT_LAST))
        else $error("MAC count ran past N");

    a_read_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_cnt <= ROT_LAST))
        else $error("read rotation count ran past N-1");

    a_read_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_cnt == ROT_LAST) |=> (r_state == S_OUT))
        else $error("full rotation did not end in output stage");

endmodule

/* rtl/negacyclic_poly_dot_product.sv */
// Negacyclic polynomial multiply-accumulate, arithmetic mod 2^Q_BITS.
// Input channel i_in (valid/ready): one beat is one command.
//   load  : writes (s, a) at coeff_index; done in the accept cycle.
//   mac   : acc += s * a in Z[x]/(x^N + 1); clear_first zeroes acc first.
//           Steps through every row of the s memory, one read a cycle,
//           registered, adding each product once its read is back, then
//           returns to idle before the next beat is taken.
//   read  : returns acc[coeff_index] on o_out with the index echoed.
//           In range it rotates the accumulator row once round, past the
//           single tap at slot 0, then loads the output register; out of
//           range it skips the rotation and loads zero.
// Index at or beyond N_COEFFS: load ignored, read gives zero. Opcode 3: no-op.
// The s/a stores read as garbage until loaded; the accumulator resets to
// zero. Reset is synchronous and active low; no beat is
// taken while it is held.
// Output is a register: the next beat is accepted while a result waits.
// If o_out stays stalled, a second read holds in its final stage until
// the register frees up, and no further beats are accepted meanwhile.
module negacyclic_poly_dot_product #(
    parameter int N_COEFFS = npd_pkg::N_COEFFS_DEF,
    parameter int Q_BITS   = npd_pkg::Q_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    npd_in_if.sink     i_in,
    npd_out_if.source  o_out
);

    // counter must hold N itself (last MAC step)
    localparam int CNT_W = $clog2(N_COEFFS + 1);

    npd_pkg::t_cmd    w_cmd;
    npd_pkg::t_sts    w_sts;
    logic [CNT_W-1:0] w_cnt;

    // Sequencer: owns the state and the row counter
    npd_ctrl #(
        .N_COEFFS (N_COEFFS),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .i_sts      (w_sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd),
        .o_cnt      (w_cnt)
    );

    // s memory, row of N MAC cells, read capture and output register
    npd_datapath #(
        .N_COEFFS (N_COEFFS),
        .Q_BITS   (Q_BITS),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cnt          (w_cnt),
        .i_coeff_index  (i_in.coeff_index),
        .i_s_coeff      (i_in.s_coeff),
        .i_a_coeff      (i_in.a_coeff),
        .i_clear_first  (i_in.clear_first),
        .i_out_ready    (o_out.ready),
        .o_sts          (w_sts),
        .o_out_valid    (o_out.valid),
        .o_result_coeff (o_out.result_coeff),
        .o_result_index (o_out.result_index)
    );

endmodule
